[sv/tws_pkg.sv]
// shared types and constants of the timing wheel scheduler
`default_nettype none

package tws_pkg;

  localparam int WHEEL_SLOTS     = 256;
  localparam int SLOT_BITS       = 8;
  localparam int CYCLE_BITS      = 32;
  localparam int OUT_HANDLE_BITS = 16;
  localparam logic [CYCLE_BITS-1:0] MAX_AHEAD = 32'd255;

  typedef enum logic {
    OP_SCHEDULE = 1'b0,
    OP_TICK     = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KIND_ACK   = 2'd0,
    KIND_DUE   = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_DISPATCH
  } state_t;

  // controls of the slot fill count store
  typedef struct packed {
    logic                 re;
    logic [SLOT_BITS-1:0] rd_slot;
    logic                 we;
    logic                 clr;
    logic [SLOT_BITS-1:0] wr_slot;
  } fill_ctl_t;

endpackage

`default_nettype wire

[sv/tws_fill_store.sv]
// per-slot fill counts: memory plus valid bits cleared at reset
`default_nettype none

module tws_fill_store import tws_pkg::*; #(
  parameter int FILL_W = 5
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire fill_ctl_t         ctl,
  input  wire logic [FILL_W-1:0] wr_fill,
  output logic      [FILL_W-1:0] rd_fill
);

  logic [FILL_W-1:0]      fill_mem [WHEEL_SLOTS];
  logic [WHEEL_SLOTS-1:0] valid;
  logic [FILL_W-1:0]      rd_raw;
  logic                   rd_vld;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      fill_mem[ctl.wr_slot] <= wr_fill;
    end
    if (ctl.re) begin
      rd_raw <= fill_mem[ctl.rd_slot];
      rd_vld <= valid[ctl.rd_slot];
    end
  end

  // an entry never written since reset or since its last tick reads as empty
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ctl.we) begin
      valid[ctl.wr_slot] <= 1'b1;
    end else if (ctl.clr) begin
      valid[ctl.wr_slot] <= 1'b0;
    end
  end

  assign rd_fill = rd_vld ? rd_raw : '0;

endmodule

`default_nettype wire

[sv/tws_handle_ram.sv]
// handle store: single write port, registered read port
`default_nettype none

module tws_handle_ram #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12,
  parameter int DATA_W = 16
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[sv/timing_wheel_event_scheduler_unit.sv]
// timing wheel scheduler top level: control sequencer and result registers
//
// A 256-slot timing wheel. A transaction is taken when start is high and busy
// is low. A schedule transaction reads the slot's fill count from its memory,
// then writes the handle and the new count back before the next one can be
// taken. A tick on an empty slot ends after the fill count read; a tick on a slot
// holding handles then dispatches them, as the handle memory gives one handle per
// cycle. Each result is shown for one cycle with strobe high, in the cycle after
// it is formed, and cannot be held off; last marks the final result of a
// transaction. No clearing pass is needed after reset: the slot counts come up
// empty at once.
`default_nettype none

module timing_wheel_event_scheduler_unit import tws_pkg::*; #(
  parameter int SLOT_CAPACITY = 16,
  parameter int HANDLE_BITS   = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       op,
  input  wire logic [OUT_HANDLE_BITS-1:0] handle,
  input  wire logic [CYCLE_BITS-1:0]      due_cycle,
  input  wire logic [CYCLE_BITS-1:0]      now_cycle,
  output logic                            strobe,
  output logic [1:0]                      kind,
  output logic [OUT_HANDLE_BITS-1:0]      due_handle,
  output logic                            clamped,
  output logic                            dropped,
  output logic                            last
);

  localparam int FILL_W = $clog2(SLOT_CAPACITY + 1);
  localparam int DEPTH  = WHEEL_SLOTS * SLOT_CAPACITY;
  localparam int ADDR_W = $clog2(DEPTH);

  state_t state, state_next;

  op_t                    op_q;
  logic [SLOT_BITS-1:0]   slot_q;
  logic [HANDLE_BITS-1:0] handle_q;
  logic                   clamped_q;
  logic [FILL_W-1:0]      count;
  logic [FILL_W-1:0]      idx;

  logic                   accept;
  logic [CYCLE_BITS-1:0]  ahead;
  logic                   in_clamp;
  logic [SLOT_BITS-1:0]   in_slot;
  logic                   is_last;
  logic                   slot_full;

  fill_ctl_t              fill_ctl;
  logic [FILL_W-1:0]      wr_fill;
  logic [FILL_W-1:0]      rd_fill;

  logic                   hm_we;
  logic                   hm_re;
  logic [FILL_W-1:0]      hm_rd_idx;
  logic [ADDR_W-1:0]      hm_wr_addr;
  logic [ADDR_W-1:0]      hm_rd_addr;
  logic [HANDLE_BITS-1:0] hm_rd_data;

  logic                       strobe_next;
  kind_t                      kind_next;
  logic [OUT_HANDLE_BITS-1:0] due_handle_next;
  logic                       clamped_next;
  logic                       dropped_next;
  logic                       last_next;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // out-of-range delay goes to now + 255, whose slot is now's slot minus one
  assign ahead    = due_cycle - now_cycle;
  assign in_clamp = (ahead > MAX_AHEAD);
  assign in_slot  = (op_t'(op) == OP_TICK) ? now_cycle[SLOT_BITS-1:0] :
                    in_clamp ? (now_cycle[SLOT_BITS-1:0] + MAX_AHEAD[SLOT_BITS-1:0]) :
                    due_cycle[SLOT_BITS-1:0];

  assign slot_full = (rd_fill >= FILL_W'(SLOT_CAPACITY));
  assign is_last   = (idx == count - FILL_W'(1));
  assign wr_fill   = rd_fill + FILL_W'(1);

  assign hm_wr_addr = ADDR_W'(slot_q) * ADDR_W'(SLOT_CAPACITY) + ADDR_W'(rd_fill);
  assign hm_rd_addr = ADDR_W'(slot_q) * ADDR_W'(SLOT_CAPACITY) + ADDR_W'(hm_rd_idx);

  tws_fill_store #(
    .FILL_W (FILL_W)
  ) u_fill (
    .clk     (clk),
    .rst     (rst),
    .ctl     (fill_ctl),
    .wr_fill (wr_fill),
    .rd_fill (rd_fill)
  );

  tws_handle_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (HANDLE_BITS)
  ) u_handles (
    .clk     (clk),
    .we      (hm_we),
    .wr_addr (hm_wr_addr),
    .wr_data (handle_q),
    .re      (hm_re),
    .rd_addr (hm_rd_addr),
    .rd_data (hm_rd_data)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_FILL;
        end
      end
      ST_FILL: begin
        if (op_q == OP_TICK && rd_fill != '0) begin
          state_next = ST_DISPATCH;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_DISPATCH: begin
        if (is_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    fill_ctl         = '0;
    fill_ctl.rd_slot = in_slot;
    fill_ctl.wr_slot = slot_q;
    hm_we            = 1'b0;
    hm_re            = 1'b0;
    hm_rd_idx        = idx + FILL_W'(1);
    strobe_next      = 1'b0;
    kind_next        = KIND_ACK;
    due_handle_next  = '0;
    clamped_next     = 1'b0;
    dropped_next     = 1'b0;
    last_next        = 1'b0;
    case (state)
      ST_IDLE: begin
        fill_ctl.re = accept;
      end
      ST_FILL: begin
        hm_rd_idx = '0;
        if (op_q == OP_SCHEDULE) begin
          fill_ctl.we  = !slot_full;
          hm_we        = !slot_full;
          strobe_next  = 1'b1;
          clamped_next = clamped_q;
          dropped_next = slot_full;
          last_next    = 1'b1;
        end else if (rd_fill == '0) begin
          strobe_next = 1'b1;
          kind_next   = KIND_EMPTY;
          last_next   = 1'b1;
        end else begin
          // count is held locally, so the slot empties now
          fill_ctl.clr = 1'b1;
          hm_re        = 1'b1;
        end
      end
      ST_DISPATCH: begin
        hm_re           = !is_last;
        strobe_next     = 1'b1;
        kind_next       = KIND_DUE;
        due_handle_next = OUT_HANDLE_BITS'(hm_rd_data);
        last_next       = is_last;
      end
      default: begin
        hm_rd_idx = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q      <= op_t'(op);
      slot_q    <= in_slot;
      handle_q  <= HANDLE_BITS'(handle);
      clamped_q <= in_clamp;
    end
    if (state == ST_FILL) begin
      count <= rd_fill;
      idx   <= '0;
    end else if (state == ST_DISPATCH) begin
      idx <= idx + FILL_W'(1);
    end
    kind       <= kind_next;
    due_handle <= due_handle_next;
    clamped    <= clamped_next;
    dropped    <= dropped_next;
    last       <= last_next;
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted transaction did not raise busy");

  a_sched_ack: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL && op_q == OP_SCHEDULE) |=> (strobe && kind == KIND_ACK && last))
    else $error("schedule gave no single acknowledge");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    (strobe && (kind == KIND_ACK || kind == KIND_EMPTY)) |-> (last && due_handle == '0))
    else $error("acknowledge or empty tick is not a lone result");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DISPATCH) |-> (idx < count))
    else $error("dispatch index ran past slot count");

  a_more_follow: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |-> busy)
    else $error("transaction ended without a last result");

endmodule

`default_nettype wire
